[design/lgi_pkg.sv]
`timescale 1ns / 1ps

package lgi_pkg;

  localparam int NODE_COUNT = 11;
  localparam int FIRST_NODE = -5;
  localparam int NODE_W     = $clog2(NODE_COUNT);

  localparam int X_W        = 16;
  localparam int Y_W        = 16;
  localparam int OUT_W      = 32;
  localparam int XQ_BITS    = 12;

  localparam int W_ONE_SHIFT = 32;
  localparam int WMAG_W      = 45;
  localparam int W_SPLIT     = 23;
  localparam int DMAG_W      = 17;
  localparam int D_W         = DMAG_W + 1;
  localparam int PROD_W      = WMAG_W + DMAG_W;
  localparam int MUL_W       = W_SPLIT + DMAG_W;

  localparam int NUM_W       = PROD_W + 1 - XQ_BITS;
  localparam int DIV_BITS    = 7;
  localparam int DIV_STEPS   = (NUM_W + DIV_BITS - 1) / DIV_BITS;
  localparam int NUM_PAD_W   = DIV_STEPS * DIV_BITS;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

  localparam int TERM_SHIFT  = 30;
  localparam int ACC_W       = 36;

  localparam int UPC_W       = 4;
  localparam int PROG_LEN    = 14;

  typedef enum logic [3:0] {
    OP_INIT,
    OP_WINIT,
    OP_SETUP,
    OP_MUL_LO,
    OP_MUL_HI,
    OP_ROUND,
    OP_DIV,
    OP_WUPD,
    OP_ADV_J,
    OP_TMUL_LO,
    OP_TMUL_HI,
    OP_TACC,
    OP_NEXTI,
    OP_FINISH
  } op_t;

  typedef enum logic [2:0] {
    C_NONE,
    C_J_EQ_I,
    C_DIV_MORE,
    C_J_MORE,
    C_I_MORE
  } cond_t;

  typedef struct packed {
    op_t               op;
    cond_t             cond;
    logic [UPC_W-1:0]  target;
  } ucode_t;

  typedef struct packed {
    logic run;
    op_t  op;
  } dp_ctrl_t;

  typedef struct packed {
    logic j_eq_i;
    logic j_more;
    logic i_more;
    logic div_more;
  } dp_stat_t;

  localparam logic [UPC_W-1:0] A_INIT    = UPC_W'(0);
  localparam logic [UPC_W-1:0] A_WINIT   = UPC_W'(1);
  localparam logic [UPC_W-1:0] A_SETUP   = UPC_W'(2);
  localparam logic [UPC_W-1:0] A_MUL_LO  = UPC_W'(3);
  localparam logic [UPC_W-1:0] A_MUL_HI  = UPC_W'(4);
  localparam logic [UPC_W-1:0] A_ROUND   = UPC_W'(5);
  localparam logic [UPC_W-1:0] A_DIV     = UPC_W'(6);
  localparam logic [UPC_W-1:0] A_WUPD    = UPC_W'(7);
  localparam logic [UPC_W-1:0] A_ADV_J   = UPC_W'(8);
  localparam logic [UPC_W-1:0] A_TMUL_LO = UPC_W'(9);
  localparam logic [UPC_W-1:0] A_TMUL_HI = UPC_W'(10);
  localparam logic [UPC_W-1:0] A_TACC    = UPC_W'(11);
  localparam logic [UPC_W-1:0] A_NEXTI   = UPC_W'(12);
  localparam logic [UPC_W-1:0] A_FINISH  = UPC_W'(13);

  function automatic ucode_t lgi_ucode(input logic [UPC_W-1:0] addr);
    ucode_t w;
    unique case (addr)
      A_INIT:    w = '{op: OP_INIT,    cond: C_NONE,     target: A_INIT};
      A_WINIT:   w = '{op: OP_WINIT,   cond: C_NONE,     target: A_INIT};
      A_SETUP:   w = '{op: OP_SETUP,   cond: C_J_EQ_I,   target: A_ADV_J};
      A_MUL_LO:  w = '{op: OP_MUL_LO,  cond: C_NONE,     target: A_INIT};
      A_MUL_HI:  w = '{op: OP_MUL_HI,  cond: C_NONE,     target: A_INIT};
      A_ROUND:   w = '{op: OP_ROUND,   cond: C_NONE,     target: A_INIT};
      A_DIV:     w = '{op: OP_DIV,     cond: C_DIV_MORE, target: A_DIV};
      A_WUPD:    w = '{op: OP_WUPD,    cond: C_NONE,     target: A_INIT};
      A_ADV_J:   w = '{op: OP_ADV_J,   cond: C_J_MORE,   target: A_SETUP};
      A_TMUL_LO: w = '{op: OP_TMUL_LO, cond: C_NONE,     target: A_INIT};
      A_TMUL_HI: w = '{op: OP_TMUL_HI, cond: C_NONE,     target: A_INIT};
      A_TACC:    w = '{op: OP_TACC,    cond: C_NONE,     target: A_INIT};
      A_NEXTI:   w = '{op: OP_NEXTI,   cond: C_I_MORE,   target: A_WINIT};
      A_FINISH:  w = '{op: OP_FINISH,  cond: C_NONE,     target: A_INIT};
      default:   w = '{op: OP_FINISH,  cond: C_NONE,     target: A_INIT};
    endcase
    return w;
  endfunction

endpackage

[design/lgi_sequencer.sv]
`timescale 1ns / 1ps

module lgi_sequencer import lgi_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     launch,
  input  dp_stat_t stat,
  output dp_ctrl_t ctrl,
  output logic     busy
);

  logic             running_r, running_nxt;
  logic [UPC_W-1:0] upc_r, upc_nxt;
  ucode_t           uw;
  logic             take;

  assign uw = lgi_ucode(upc_r);

  always_comb begin
    case (uw.cond)
      C_NONE:     take = 1'b0;
      C_J_EQ_I:   take = stat.j_eq_i;
      C_DIV_MORE: take = stat.div_more;
      C_J_MORE:   take = stat.j_more;
      C_I_MORE:   take = stat.i_more;
      default:    take = 1'b0;
    endcase
  end

  always_comb begin
    running_nxt = running_r;
    upc_nxt     = upc_r;
    if (launch) begin
      running_nxt = 1'b1;
      upc_nxt     = A_INIT;
    end else if (running_r) begin
      if (uw.op == OP_FINISH) begin
        running_nxt = 1'b0;
      end
      upc_nxt = take ? uw.target : upc_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
      upc_r     <= A_INIT;
    end else begin
      running_r <= running_nxt;
      upc_r     <= upc_nxt;
    end
  end

  assign ctrl.run = running_r;
  assign ctrl.op  = uw.op;
  assign busy     = running_r;

`ifndef SYNTHESIS
  a_finish_stops: assert property (@(posedge clk) disable iff (!rst_n)
    running_r && uw.op == OP_FINISH |=> !running_r)
    else $error("sequencer kept running past the finish step");

  a_upc_in_program: assert property (@(posedge clk) disable iff (!rst_n)
    running_r |-> upc_r < UPC_W'(PROG_LEN))
    else $error("step counter left the program");

  a_launch_at_start: assert property (@(posedge clk) disable iff (!rst_n)
    launch |=> running_r && upc_r == A_INIT)
    else $error("launch did not enter the program at its first step");
`endif

endmodule

[design/lgi_datapath.sv]
`timescale 1ns / 1ps

module lgi_datapath import lgi_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  dp_ctrl_t                ctrl,
  input  logic                    wr_en,
  input  logic [NODE_W-1:0]       wr_idx,
  input  logic [Y_W-1:0]          wr_data,
  input  logic                    ld_x,
  input  logic signed [X_W-1:0]   x_in,
  output dp_stat_t                stat,
  output logic                    out_valid,
  output logic signed [OUT_W-1:0] out_value,
  output logic                    out_sat
);

  logic [Y_W-1:0]           samp_r [NODE_COUNT];
  logic signed [X_W-1:0]    x_r;

  logic [NODE_W-1:0]        i_r, i_nxt;
  logic [NODE_W-1:0]        j_r, j_nxt;
  logic [DIV_CNT_W-1:0]     div_cnt_r, div_cnt_nxt;
  logic                     out_valid_r, out_valid_nxt;

  logic [WMAG_W-1:0]        wmag_r, wmag_nxt;
  logic                     wsign_r, wsign_nxt;
  logic [DMAG_W-1:0]        dmag_r, dmag_nxt;
  logic [NODE_W-1:0]        gap_r, gap_nxt;
  logic                     flip_r, flip_nxt;
  logic [PROD_W-1:0]        prod_r, prod_nxt;
  logic [NUM_PAD_W-1:0]     num_r, num_nxt;
  logic [NODE_W-1:0]        rem_r, rem_nxt;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic                     sat_r, sat_nxt;
  logic signed [OUT_W-1:0]  out_value_r, out_value_nxt;
  logic                     out_sat_r, out_sat_nxt;

  logic [Y_W-1:0]           y_bits;
  logic [Y_W-1:0]           ymag;
  logic                     tneg;
  logic signed [D_W-1:0]    x_ext, j_ext, first_ext, d_val;
  logic                     d_neg;
  logic [NODE_W:0]          g_val;
  logic                     g_neg;
  logic                     mul_hi, mul_term;
  logic [W_SPLIT-1:0]       mul_a;
  logic [DMAG_W-1:0]        mul_b;
  logic [MUL_W-1:0]         mul_p;
  logic [PROD_W:0]          rnd_sum, trm_sum;
  logic [ACC_W-1:0]         trm;
  logic [ACC_W-OUT_W:0]     acc_top;
  logic                     in_range;
  logic [NODE_W-1:0]        dv_rem;
  logic [NODE_W:0]          dv_try;
  logic [NUM_PAD_W-1:0]     dv_num;

  // node difference and gap for the current pair
  assign x_ext     = {{(D_W-X_W){x_r[X_W-1]}}, x_r};
  assign j_ext     = {{(D_W-NODE_W){1'b0}}, j_r};
  assign first_ext = D_W'(FIRST_NODE);
  assign d_val     = x_ext - ((first_ext + j_ext) <<< XQ_BITS);
  assign d_neg     = d_val[D_W-1];
  assign g_val     = {1'b0, i_r} - {1'b0, j_r};
  assign g_neg     = g_val[NODE_W];

  assign y_bits    = samp_r[i_r];
  assign ymag      = y_bits[Y_W-1] ? (~y_bits + 1'b1) : y_bits;
  assign tneg      = wsign_r ^ y_bits[Y_W-1];

  // shared multiplier over the two halves of the weight
  assign mul_hi    = (ctrl.op == OP_MUL_HI) || (ctrl.op == OP_TMUL_HI);
  assign mul_term  = (ctrl.op == OP_TMUL_LO) || (ctrl.op == OP_TMUL_HI);
  assign mul_a     = mul_hi ? W_SPLIT'(wmag_r[WMAG_W-1:W_SPLIT]) : wmag_r[W_SPLIT-1:0];
  assign mul_b     = mul_term ? DMAG_W'(ymag) : dmag_r;
  assign mul_p     = mul_a * mul_b;

  assign rnd_sum   = (PROD_W+1)'(prod_r) + ((PROD_W+1)'(gap_r) << (XQ_BITS - 1));
  assign trm_sum   = (PROD_W+1)'(prod_r) + ((PROD_W+1)'(1) << (TERM_SHIFT - 1));
  assign trm       = ACC_W'(trm_sum >> TERM_SHIFT);

  assign acc_top   = acc_r[ACC_W-1:OUT_W-1];
  assign in_range  = (&acc_top) | ~(|acc_top);

  // restoring divide by the gap, several quotient bits a cycle
  always_comb begin
    dv_rem = rem_r;
    dv_num = num_r;
    dv_try = '0;
    for (int k = 0; k < DIV_BITS; k++) begin
      dv_try = {dv_rem, dv_num[NUM_PAD_W-1]};
      dv_num = {dv_num[NUM_PAD_W-2:0], 1'b0};
      if (dv_try >= {1'b0, gap_r}) begin
        dv_rem    = NODE_W'(dv_try - {1'b0, gap_r});
        dv_num[0] = 1'b1;
      end else begin
        dv_rem = dv_try[NODE_W-1:0];
      end
    end
  end

  always_comb begin
    i_nxt         = i_r;
    j_nxt         = j_r;
    div_cnt_nxt   = div_cnt_r;
    out_valid_nxt = 1'b0;
    wmag_nxt      = wmag_r;
    wsign_nxt     = wsign_r;
    dmag_nxt      = dmag_r;
    gap_nxt       = gap_r;
    flip_nxt      = flip_r;
    prod_nxt      = prod_r;
    num_nxt       = num_r;
    rem_nxt       = rem_r;
    acc_nxt       = acc_r;
    sat_nxt       = sat_r;
    out_value_nxt = out_value_r;
    out_sat_nxt   = out_sat_r;
    if (ctrl.run) begin
      unique case (ctrl.op) inside
        OP_INIT: begin
          i_nxt   = '0;
          acc_nxt = '0;
          sat_nxt = 1'b0;
        end
        OP_WINIT: begin
          wmag_nxt  = WMAG_W'(1) << W_ONE_SHIFT;
          wsign_nxt = 1'b0;
          j_nxt     = '0;
        end
        OP_SETUP: begin
          dmag_nxt = DMAG_W'(d_neg ? -d_val : d_val);
          gap_nxt  = NODE_W'(g_neg ? -g_val : g_val);
          flip_nxt = d_neg ^ g_neg;
        end
        OP_MUL_LO, OP_TMUL_LO: begin
          prod_nxt = PROD_W'(mul_p);
        end
        OP_MUL_HI, OP_TMUL_HI: begin
          prod_nxt = prod_r + (PROD_W'(mul_p) << W_SPLIT);
        end
        OP_ROUND: begin
          num_nxt     = NUM_PAD_W'(rnd_sum >> XQ_BITS);
          rem_nxt     = '0;
          div_cnt_nxt = '0;
        end
        OP_DIV: begin
          num_nxt     = dv_num;
          rem_nxt     = dv_rem;
          div_cnt_nxt = div_cnt_r + 1'b1;
        end
        OP_WUPD: begin
          wsign_nxt = wsign_r ^ flip_r;
          if (|num_r[NUM_PAD_W-1:WMAG_W]) begin
            wmag_nxt = '1;
            sat_nxt  = 1'b1;
          end else begin
            wmag_nxt = num_r[WMAG_W-1:0];
          end
        end
        OP_ADV_J: begin
          j_nxt = j_r + 1'b1;
        end
        OP_TACC: begin
          acc_nxt = tneg ? acc_r - signed'(trm) : acc_r + signed'(trm);
        end
        OP_NEXTI: begin
          i_nxt = i_r + 1'b1;
        end
        OP_FINISH: begin
          out_valid_nxt = 1'b1;
          out_sat_nxt   = sat_r | ~in_range;
          if (in_range) begin
            out_value_nxt = acc_r[OUT_W-1:0];
          end else if (acc_r[ACC_W-1]) begin
            out_value_nxt = {1'b1, {(OUT_W-1){1'b0}}};
          end else begin
            out_value_nxt = {1'b0, {(OUT_W-1){1'b1}}};
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_r         <= '0;
      j_r         <= '0;
      div_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      for (int n = 0; n < NODE_COUNT; n++) begin
        samp_r[n] <= '0;
      end
    end else begin
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      div_cnt_r   <= div_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (wr_en) begin
        samp_r[wr_idx] <= wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld_x) begin
      x_r <= x_in;
    end
    wmag_r      <= wmag_nxt;
    wsign_r     <= wsign_nxt;
    dmag_r      <= dmag_nxt;
    gap_r       <= gap_nxt;
    flip_r      <= flip_nxt;
    prod_r      <= prod_nxt;
    num_r       <= num_nxt;
    rem_r       <= rem_nxt;
    acc_r       <= acc_nxt;
    sat_r       <= sat_nxt;
    out_value_r <= out_value_nxt;
    out_sat_r   <= out_sat_nxt;
  end

  assign stat.j_eq_i   = (j_r == i_r);
  assign stat.j_more   = (j_r != NODE_W'(NODE_COUNT - 1));
  assign stat.i_more   = (i_r != NODE_W'(NODE_COUNT - 1));
  assign stat.div_more = (div_cnt_r != DIV_CNT_W'(DIV_STEPS - 1));

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;
  assign out_sat   = out_sat_r;

`ifndef SYNTHESIS
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe held for more than one cycle");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.run && ctrl.op == OP_DIV |-> gap_r != '0)
    else $error("divide step with a zero gap");

  a_div_complete: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.run && ctrl.op == OP_WUPD |-> div_cnt_r == DIV_CNT_W'(DIV_STEPS))
    else $error("weight update before the divide loop finished");
`endif

endmodule

[design/lagrange_interpolator_unit.sv]
`timescale 1ns / 1ps

// Channel   Ports                                      Transaction
// input     start, busy, in_action, in_node_index,     start high while busy low
//           in_sample_value, in_x_value
// result    out_valid, out_interp_value, out_saturated one cycle with out_valid high
//
// A sample write leaves busy low and produces no result.
// An evaluate runs 1619 microcode steps, busy high throughout: eleven terms, each with
// ten weight updates of 14 steps (two passes through the 23x17 multiplier, a round,
// and eight 7-bit passes of the divide-by-gap loop), then the strobe follows.
// rst_n clears the sample table to zero and stops any evaluate in progress.
// The receiver cannot stall; each result is presented for exactly one cycle.

module lagrange_interpolator_unit import lgi_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic                    in_action,
  input  logic [3:0]              in_node_index,
  input  logic signed [Y_W-1:0]   in_sample_value,
  input  logic signed [X_W-1:0]   in_x_value,
  output logic                    out_valid,
  output logic signed [OUT_W-1:0] out_interp_value,
  output logic                    out_saturated
);

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_EVAL  = 1'b1;

  logic     accept;
  logic     launch;
  logic     wr_en;
  dp_ctrl_t ctrl;
  dp_stat_t stat;

  assign accept = start & ~busy;
  assign launch = accept & (in_action == ACT_EVAL);
  assign wr_en  = accept & (in_action == ACT_WRITE)
                & ({1'b0, in_node_index} < 5'(NODE_COUNT));

  lgi_sequencer u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .launch (launch),
    .stat   (stat),
    .ctrl   (ctrl),
    .busy   (busy)
  );

  lgi_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .wr_en     (wr_en),
    .wr_idx    (NODE_W'(in_node_index)),
    .wr_data   (in_sample_value),
    .ld_x      (launch),
    .x_in      (in_x_value),
    .stat      (stat),
    .out_valid (out_valid),
    .out_value (out_interp_value),
    .out_sat   (out_saturated)
  );

endmodule
